// ----- hdl/knsel_pkg.sv -----
// ----------------------------------------------------------------------------
// knsel_pkg: shared definitions for the nearest-to-origin selector
// Default sizes, register map and the command word of the cell chain.
// ----------------------------------------------------------------------------
package knsel_pkg;

  // default sizes
  localparam int MAX_KEEP_DEF   = 16;
  localparam int COORD_BITS_DEF = 16;

  // squared distance, saturated
  localparam int DIST_BITS = 32;

  // configuration register file
  localparam int KEEP_BITS      = 5;
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;
  localparam logic [KEEP_BITS-1:0] KEEP_RESET = KEEP_BITS'(1);

  // register index (byte address / 4)
  localparam logic REG_KEEP_COUNT = 1'b0;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;    // rank the new point into the chain
    logic drain;  // move every entry one cell toward the head
  } chain_cmd_t;

endpackage

// ----- hdl/knsel_in_if.sv -----
// ----------------------------------------------------------------------------
// knsel_in_if: point input channel
// Valid/ready channel carrying one point and its end-of-set mark.
// ----------------------------------------------------------------------------
interface knsel_in_if
  import knsel_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         set_end;

  modport source (output valid, point_x, point_y, set_end, input ready);
  modport sink   (input valid, point_x, point_y, set_end, output ready);
endinterface

// ----- hdl/knsel_out_if.sv -----
// ----------------------------------------------------------------------------
// knsel_out_if: selected point output channel
// Valid/ready channel carrying one selected point and its end-of-run mark.
// ----------------------------------------------------------------------------
interface knsel_out_if
  import knsel_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] near_x;
  logic signed [COORD_BITS-1:0] near_y;
  logic                         run_end;

  modport source (output valid, near_x, near_y, run_end, input ready);
  modport sink   (input valid, near_x, near_y, run_end, output ready);
endinterface

// ----- hdl/knsel_dist.sv -----
// ----------------------------------------------------------------------------
// knsel_dist: squared distance pipeline
// Stage A squares the coordinate magnitudes, stage B adds and saturates.
// ----------------------------------------------------------------------------
module knsel_dist
  import knsel_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  input  logic                  in_end,
  output logic                  b_valid,
  output logic                  b_end,
  output logic [COORD_BITS-1:0] b_x,
  output logic [COORD_BITS-1:0] b_y,
  output logic [DIST_BITS-1:0]  b_dist
);

  localparam int SQ_BITS  = 2 * COORD_BITS;
  localparam int SUM_BITS = SQ_BITS + 1;

  logic [COORD_BITS-1:0] mag_x, mag_y;
  logic                  a_valid, a_end;
  logic [COORD_BITS-1:0] a_x, a_y;
  logic [SQ_BITS-1:0]    sq_x, sq_y;
  logic [SUM_BITS-1:0]   sum;
  logic [DIST_BITS-1:0]  dist_next;

  // two's complement magnitude; the most negative value maps to 2^(N-1)
  assign mag_x = in_x[COORD_BITS-1] ? (~in_x + COORD_BITS'(1)) : in_x;
  assign mag_y = in_y[COORD_BITS-1] ? (~in_y + COORD_BITS'(1)) : in_y;

  // stage A control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  // stage A payload: one multiplier per coordinate
  always_ff @(posedge clk) begin
    a_end <= in_end;
    a_x   <= in_x;
    a_y   <= in_y;
    sq_x  <= SQ_BITS'(mag_x) * SQ_BITS'(mag_x);
    sq_y  <= SQ_BITS'(mag_y) * SQ_BITS'(mag_y);
  end

  assign sum = SUM_BITS'(sq_x) + SUM_BITS'(sq_y);

  // saturate to the distance width
  generate
    if (SUM_BITS > DIST_BITS) begin : g_sat
      assign dist_next = (|sum[SUM_BITS-1:DIST_BITS]) ? '1 : sum[DIST_BITS-1:0];
    end else begin : g_fit
      assign dist_next = DIST_BITS'(sum);
    end
  endgenerate

  // stage B control
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  // stage B payload
  always_ff @(posedge clk) begin
    b_end  <= a_end;
    b_x    <= a_x;
    b_y    <= a_y;
    b_dist <= dist_next;
  end

endmodule

// ----- hdl/knsel_cell.sv -----
// ----------------------------------------------------------------------------
// knsel_cell: one slot of the sorted insertion chain
// Holds one kept point; on insert it keeps, takes the new point or takes its
// left neighbor; on drain it takes its right neighbor.
// ----------------------------------------------------------------------------
module knsel_cell
  import knsel_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  chain_cmd_t            cmd,
  input  logic                  en,          // slot lies below the keep limit
  input  logic [COORD_BITS-1:0] new_x,
  input  logic [COORD_BITS-1:0] new_y,
  input  logic [DIST_BITS-1:0]  new_dist,
  input  logic                  left_valid,
  input  logic                  left_le,     // left slot ranks before the new point
  input  logic [COORD_BITS-1:0] left_x,
  input  logic [COORD_BITS-1:0] left_y,
  input  logic [DIST_BITS-1:0]  left_dist,
  input  logic                  right_valid,
  input  logic [COORD_BITS-1:0] right_x,
  input  logic [COORD_BITS-1:0] right_y,
  input  logic [DIST_BITS-1:0]  right_dist,
  output logic                  valid,
  output logic                  le,
  output logic [COORD_BITS-1:0] x,
  output logic [COORD_BITS-1:0] y,
  output logic [DIST_BITS-1:0]  slot_dist
);

  logic held;
  logic take_new, take_left;

  // slots beyond the limit read as empty
  assign valid = held && en;
  // equal distance ranks first: a new point never displaces an equal one
  assign le    = valid && !(slot_dist > new_dist);

  assign take_new  = !le && left_le;
  assign take_left = left_valid && !left_le;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (cmd.ins) begin
      held <= en && (held || take_new || take_left);
    end else if (cmd.drain) begin
      held <= en && right_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (take_new) begin
        x         <= new_x;
        y         <= new_y;
        slot_dist <= new_dist;
      end else if (take_left) begin
        x         <= left_x;
        y         <= left_y;
        slot_dist <= left_dist;
      end
    end else if (cmd.drain) begin
      x         <= right_x;
      y         <= right_y;
      slot_dist <= right_dist;
    end
  end

endmodule

// ----- hdl/k_nearest_to_origin_select_top.sv -----
// ----------------------------------------------------------------------------
// k_nearest_to_origin_select_top: keeps the k points nearest the origin
// Points stream in on in_ch; on the last point of a set the kept points
// leave on out_ch in ascending squared distance, the last one marked.
// Usage:
//   - keep_count (APB, byte address 0) sets k, 1..MAX_KEEP; 0 acts as 1.
//     Write it only while the block is idle.
//   - in_ch takes one point per cycle while a set is being collected; the
//     squared distance takes two pipeline stages, then the point is ranked
//     into a chain of MAX_KEEP cells.
//   - A point with set_end closes the set: in_ch.ready drops, and the first
//     result follows once that point has been ranked into the chain. The n kept
//     points then leave one per cycle, paced by out_ch.ready through the
//     output register; the chain shifts toward its head each time one leaves.
//   - After the last result is taken from the chain in_ch.ready returns.
//   - Reset empties the chain and the output register and sets keep_count
//     to 1. A stalled receiver simply holds the chain and the output word.
// ----------------------------------------------------------------------------
module k_nearest_to_origin_select_top
  import knsel_pkg::*;
#(
  parameter int MAX_KEEP   = MAX_KEEP_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  knsel_in_if.sink                 in_ch,
  knsel_out_if.source              out_ch
);

  localparam int LIM_BITS = $clog2(MAX_KEEP + 1);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } state_t;

  state_t state, state_next;

  logic [KEEP_BITS-1:0] keep_count;
  logic [LIM_BITS-1:0]  limit;
  logic [MAX_KEEP-1:0]  cell_en;

  logic                  b_valid, b_end;
  logic [COORD_BITS-1:0] b_x, b_y;
  logic [DIST_BITS-1:0]  b_dist;
  logic                  a_hold_end, b_hold_end;
  logic                  in_take;

  chain_cmd_t            cmd;
  logic [MAX_KEEP-1:0]   c_valid, c_le;
  logic [COORD_BITS-1:0] c_x    [MAX_KEEP];
  logic [COORD_BITS-1:0] c_y    [MAX_KEEP];
  logic [DIST_BITS-1:0]  c_dist [MAX_KEEP];
  logic [MAX_KEEP:0]     valid_ext;
  logic                  out_load;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_KEEP_COUNT)) begin
      keep_count <= pwdata[KEEP_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_KEEP_COUNT) ? APB_DATA_BITS'(keep_count) : '0;

  // effective limit and the slots it enables
  always_comb begin
    if (keep_count == '0) begin
      limit = LIM_BITS'(1);
    end else if (int'(keep_count) > MAX_KEEP) begin
      limit = LIM_BITS'(MAX_KEEP);
    end else begin
      limit = LIM_BITS'(keep_count);
    end
    for (int i = 0; i < MAX_KEEP; i++) begin
      cell_en[i] = (i < int'(limit));
    end
  end

  // ---------------- input and distance pipeline ----------------
  // hold off new points once the closing point of a set is in flight
  assign in_ch.ready = (state == ST_COLLECT) && !a_hold_end && !b_hold_end;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign b_hold_end  = b_valid && b_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_hold_end <= 1'b0;
    end else begin
      a_hold_end <= in_take && in_ch.set_end;
    end
  end

  knsel_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_take),
    .in_x     (in_ch.point_x),
    .in_y     (in_ch.point_y),
    .in_end   (in_ch.set_end),
    .b_valid  (b_valid),
    .b_end    (b_end),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_dist   (b_dist)
  );

  // ---------------- sequencing ----------------
  assign out_load  = (state == ST_DRAIN) && c_valid[0] && (!out_ch.valid || out_ch.ready);
  assign cmd.ins   = (state == ST_COLLECT) && b_valid;
  assign cmd.drain = out_load;

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: if (b_hold_end) state_next = ST_DRAIN;
      ST_DRAIN:   if (!c_valid[0]) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- insertion chain ----------------
  generate
    for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      logic                  l_valid, l_le, r_valid;
      logic [COORD_BITS-1:0] l_x, l_y, r_x, r_y;
      logic [DIST_BITS-1:0]  l_dist, r_dist;

      if (i == 0) begin : g_head
        // head slot: nothing ranks before it
        assign l_valid = 1'b0;
        assign l_le    = 1'b1;
        assign l_x     = '0;
        assign l_y     = '0;
        assign l_dist  = '0;
      end else begin : g_body
        assign l_valid = c_valid[i-1];
        assign l_le    = c_le[i-1];
        assign l_x     = c_x[i-1];
        assign l_y     = c_y[i-1];
        assign l_dist  = c_dist[i-1];
      end

      if (i == MAX_KEEP - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_x     = '0;
        assign r_y     = '0;
        assign r_dist  = '0;
      end else begin : g_mid
        assign r_valid = c_valid[i+1];
        assign r_x     = c_x[i+1];
        assign r_y     = c_y[i+1];
        assign r_dist  = c_dist[i+1];
      end

      knsel_cell #(
        .COORD_BITS (COORD_BITS)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .en          (cell_en[i]),
        .new_x       (b_x),
        .new_y       (b_y),
        .new_dist    (b_dist),
        .left_valid  (l_valid),
        .left_le     (l_le),
        .left_x      (l_x),
        .left_y      (l_y),
        .left_dist   (l_dist),
        .right_valid (r_valid),
        .right_x     (r_x),
        .right_y     (r_y),
        .right_dist  (r_dist),
        .valid       (c_valid[i]),
        .le          (c_le[i]),
        .x           (c_x[i]),
        .y           (c_y[i]),
        .slot_dist   (c_dist[i])
      );
    end
  endgenerate

  // ---------------- output register ----------------
  assign valid_ext = {1'b0, c_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.near_x  <= c_x[0];
      out_ch.near_y  <= c_y[0];
      out_ch.run_end <= !valid_ext[1];
    end
  end

endmodule

// ----- dv/k_nearest_to_origin_select_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// k_nearest_to_origin_select_top_tb: self-checking bench for the k-nearest selector
// Streams sets of 2-D points into the selector under several keep_count
// settings and checks every selected point against a local ranking model or,
// for typed rows, the table entry. A short table of directed points runs first,
// then random sets. Both channels idle in short random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module k_nearest_to_origin_select_top_tb;
  import knsel_pkg::*;

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

  // one selected point as it leaves the block
  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } near_pt_t;

  // per input transaction: is the result typed into the table?
  typedef struct {
    bit       typed;
    near_pt_t want;
  } row_tag_t;

  // directed stimulus row; cfg is the keep_count written before the point
  typedef struct {
    int     cfg;
    coord_t x;
    coord_t y;
    logic   last;
    bit     typed;
    coord_t ex;
    coord_t ey;
  } stim_row_t;

  localparam int NO_WRITE      = -1;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_POINTS  = 9;
  localparam int NUM_PHASES    = 7;
  localparam logic [APB_ADDR_BITS-1:0] KEEP_ADDR = APB_ADDR_BITS'(4 * REG_KEEP_COUNT);
  localparam int NUM_ROWS = 23;

  // directed table: reset value, ties, extremes, zero and oversize counts,
  // count lowered mid-set, short sets, far points pushed out by a near one
  stim_row_t plan [NUM_ROWS] = '{
    '{NO_WRITE, -16'sd32768, -16'sd32768, 1'b1, 1'b1, -16'sd32768, -16'sd32768},
    '{NO_WRITE, 16'sd100, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, 16'sd0, -16'sd100, 1'b1, 1'b1, 16'sd100, 16'sd0},
    '{NO_WRITE, 16'sd32767, -16'sd32768, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, 16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd0, 16'sd0},
    '{0, 16'sd3, 16'sd4, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, -16'sd5, 16'sd0, 1'b1, 1'b1, 16'sd3, 16'sd4},
    '{16, 16'sd1, 16'sd1, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, -16'sd32768, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, 16'sd7, -16'sd7, 1'b1, 1'b0, 16'sd0, 16'sd0},
    '{31, 16'sd2, 16'sd2, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, 16'sd2, -16'sd2, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, -16'sd2, 16'sd2, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, 16'sd0, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, -16'sd1, -16'sd1, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{2, 16'sd9, 16'sd9, 1'b1, 1'b0, 16'sd0, 16'sd0},
    '{3, 16'sd32767, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, -16'sd32768, 16'sd32767, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, -16'sd32768, -16'sd32768, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, 16'sd32767, -16'sd1, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, 16'sd1, 16'sd0, 1'b1, 1'b0, 16'sd0, 16'sd0},
    '{1, -16'sd1, 16'sd0, 1'b0, 1'b0, 16'sd0, 16'sd0},
    '{NO_WRITE, 16'sd0, 16'sd1, 1'b1, 1'b1, -16'sd1, 16'sd0}
  };

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  knsel_in_if  #(.COORD_BITS(COORD_BITS_DEF)) in_ch ();
  knsel_out_if #(.COORD_BITS(COORD_BITS_DEF)) out_ch ();

  k_nearest_to_origin_select_top #(
    .MAX_KEEP   (MAX_KEEP_DEF),
    .COORD_BITS (COORD_BITS_DEF)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ranking model state
  near_pt_t    held_pt   [MAX_KEEP_DEF];
  logic [31:0] held_dist [MAX_KEEP_DEF];
  int          held_n;
  logic [KEEP_BITS-1:0] keep_reg;

  near_pt_t nearest_q [$];   // selected points still to come out
  row_tag_t typed_q   [$];   // one tag per point driven, in order
  near_pt_t picks     [$];
  row_tag_t tag;

  int  fails;
  int  points_sent;
  int  sets_sent;
  int  results_seen;
  int  settings_used;
  int  stall_left;
  bit  calm;

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fails++;
  endtask

  // squared distance at full width, saturated to 32 bits
  function automatic logic [31:0] sq_norm(coord_t x, coord_t y);
    longint ax;
    longint ay;
    longint d;
    ax = x;
    ay = y;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    d = ax * ax + ay * ay;
    if (d > 64'sh0000_0000_FFFF_FFFF) d = 64'sh0000_0000_FFFF_FFFF;
    return d[31:0];
  endfunction

  function automatic int keep_limit();
    if (keep_reg == 0) return 1;
    if (keep_reg > MAX_KEEP_DEF) return MAX_KEEP_DEF;
    return int'(keep_reg);
  endfunction

  // rank one point into the store; on set end, list the kept points
  function automatic void rank_and_select(coord_t x, coord_t y, logic last,
                                          ref near_pt_t sel[$]);
    int          lim;
    int          pos;
    int          i;
    int          n;
    logic [31:0] d;
    near_pt_t    p;
    lim = keep_limit();
    d   = sq_norm(x, y);
    if (held_n > lim) held_n = lim;
    pos = held_n;
    while (pos > 0 && held_dist[pos-1] > d) pos--;
    if (pos < lim) begin
      i = (held_n < lim) ? held_n : lim - 1;
      while (i > pos) begin
        held_pt[i]   = held_pt[i-1];
        held_dist[i] = held_dist[i-1];
        i--;
      end
      held_pt[pos]   = '{x: x, y: y, last: 1'b0};
      held_dist[pos] = d;
      if (held_n < lim) held_n++;
    end
    if (last) begin
      n = (held_n > lim) ? lim : held_n;
      for (i = 0; i < n; i++) begin
        p      = held_pt[i];
        p.last = (i + 1 == n);
        sel    = {sel, p};
      end
      held_n = 0;
    end
  endfunction

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        if (typed_q.size() != 0) begin
          tag = typed_q.pop_front();
        end else begin
          tag.typed = 1'b0;
          tag.want  = '{x: '0, y: '0, last: 1'b0};
        end
        picks.delete();
        rank_and_select(in_ch.point_x, in_ch.point_y, in_ch.set_end, picks);
        if (tag.typed) nearest_q = {nearest_q, tag.want};
        else nearest_q = {nearest_q, picks};
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (nearest_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected point (%0d,%0d) run_end=%0b",
                                  out_ch.near_x, out_ch.near_y, out_ch.run_end));
        end else begin
          near_pt_t want;
          want = nearest_q.pop_front();
          if (out_ch.near_x !== want.x)
            flag_mismatch($sformatf("near_x got %0d want %0d", out_ch.near_x, want.x));
          if (out_ch.near_y !== want.y)
            flag_mismatch($sformatf("near_y got %0d want %0d", out_ch.near_y, want.y));
          if (out_ch.run_end !== want.last)
            flag_mismatch($sformatf("run_end got %b want %b", out_ch.run_end, want.last));
        end
      end
    end
    // receiver drops ready at random, in bursts, unless calm is set
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // one APB transaction: setup cycle, then access until pready
  task automatic apb_access(bit wr, logic [APB_DATA_BITS-1:0] wdata,
                            output logic [APB_DATA_BITS-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= KEEP_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold the sender until every expected point is out and the chain is quiet
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write keep_count while idle, then read it back
  task automatic set_keep(int v);
    logic [APB_DATA_BITS-1:0] rd;
    wait_drained();
    apb_access(1'b1, APB_DATA_BITS'(v), rd);
    keep_reg = KEEP_BITS'(v);
    settings_used++;
    @(posedge clk);
    apb_access(1'b0, '0, rd);
    if (rd !== APB_DATA_BITS'(keep_reg))
      flag_mismatch($sformatf("keep_count read back %0d want %0d", rd, keep_reg));
  endtask

  // drive one point, with an occasional gap before it
  task automatic send_point(coord_t x, coord_t y, logic last, bit typed,
                            coord_t ex, coord_t ey);
    row_tag_t rt;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    rt.typed = typed;
    rt.want  = '{x: ex, y: ey, last: 1'b1};
    typed_q  = {typed_q, rt};
    in_ch.valid   <= 1'b1;
    in_ch.point_x <= x;
    in_ch.point_y <= y;
    in_ch.set_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    points_sent++;
    if (last) sets_sent++;
  endtask

  // corners, a small cluster near the origin for ties, or anything
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      1, 2, 3: return coord_t'(int'($urandom_range(0, 16)) - 8);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // run timeout
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int phase_keep [NUM_PHASES];
    int in_phase;
    int set_len;

    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.set_end = 1'b0;
    out_ch.ready  = 1'b1;
    keep_reg      = KEEP_RESET;
    held_n        = 0;
    fails         = 0;
    points_sent   = 0;
    sets_sent     = 0;
    results_seen  = 0;
    settings_used = 1;
    stall_left    = 0;
    calm          = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (plan[r].cfg != NO_WRITE) set_keep(plan[r].cfg);
      send_point(plan[r].x, plan[r].y, plan[r].last, plan[r].typed,
                 plan[r].ex, plan[r].ey);
    end

    // random sets, one keep_count per phase; last phase runs without gaps
    phase_keep = '{16, 5, 1, 31, 0, int'($urandom_range(1, 16)), 12};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_keep(phase_keep[ph]);
      if (ph == NUM_PHASES - 1) calm = 1'b1;
      in_phase = 0;
      while (in_phase < PHASE_POINTS) begin
        set_len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 24)
                                               : $urandom_range(1, 8);
        for (int i = 0; i < set_len; i++)
          send_point(pick_coord(), pick_coord(), (i == set_len - 1), 1'b0, '0, '0);
        in_phase += set_len;
        // in phase 2 the sender holds after each set but the last until the block has emptied
        if (ph == 2 && in_phase < PHASE_POINTS) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (nearest_q.size() != 0)
      flag_mismatch($sformatf("%0d selected points never came out", nearest_q.size()));

    $display("Sent %0d points in %0d sets over %0d keep_count settings;",
             points_sent, sets_sent, settings_used);
    $display("checked %0d selected points, %0d mismatches.", results_seen, fails);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/knsel_pkg.sv
hdl/knsel_in_if.sv
hdl/knsel_out_if.sv
hdl/knsel_dist.sv
hdl/knsel_cell.sv
hdl/k_nearest_to_origin_select_top.sv
dv/k_nearest_to_origin_select_top_tb.sv
